// ===== design/ksm_pkg.sv =====
`default_nettype none

package ksm_pkg;

  // Default sizes, handed to the top level's parameters.
  localparam int NUM_POINTS_DEF = 16;
  localparam int TAPS_DEF       = 4;

  localparam int NUM_AXES   = 3;
  localparam int IDX_W      = 4;
  localparam int DATA_W     = 32;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_SHIFT = 14;
  localparam int ROUND_BIAS = 8192;

  // Product, pair sum, full sum and rounded sum widths.
  localparam int PROD_W = DATA_W + COEF_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RND_W  = PROD_W + 3;
  localparam int SHR_W  = RND_W - FRAC_SHIFT;

  localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_OLDEST     = 3'd0,
    REG_COEF_MIDDLE     = 3'd1,
    REG_COEF_PREVIOUS   = 3'd2,
    REG_COEF_SAMPLE     = 3'd3,
    REG_INVALID_Z_LIMIT = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic        [IDX_W-1:0]  point_index;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic        [IDX_W-1:0]  out_index;
    logic signed [DATA_W-1:0] filt_x;
    logic signed [DATA_W-1:0] filt_y;
    logic signed [DATA_W-1:0] filt_z;
    logic                     held;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_oldest;
    logic signed [COEF_W-1:0] coef_middle;
    logic signed [COEF_W-1:0] coef_previous;
    logic signed [COEF_W-1:0] coef_sample;
    logic signed [DATA_W-1:0] invalid_z_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    coef_oldest:     16'sd0,
    coef_middle:     16'sd0,
    coef_previous:   16'sd0,
    coef_sample:     16'sd16384,
    invalid_z_limit: -32'sd5898240
  };

  // Keypoints whose history write is still outstanding in the pipeline.
  typedef struct packed {
    logic             s1_busy;
    logic [IDX_W-1:0] s1_idx;
    logic             s2_busy;
    logic [IDX_W-1:0] s2_idx;
    logic             s3_busy;
    logic [IDX_W-1:0] s3_idx;
  } pipe_status_t;

  function automatic logic signed [PROD_W-1:0] mul(input logic signed [COEF_W-1:0] c,
                                                   input logic signed [DATA_W-1:0] v);
    mul = PROD_W'(c) * PROD_W'(v);
  endfunction

  // Round half up to Q16.16, then saturate to the data width.
  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
    logic signed [RND_W-1:0] t;
    logic        [SHR_W-1:0] q;
    t = RND_W'(s) + RND_W'(ROUND_BIAS);
    q = t[RND_W-1:FRAC_SHIFT];
    if ((&q[SHR_W-1:DATA_W-1]) || !(|q[SHR_W-1:DATA_W-1])) begin
      round_sat = q[DATA_W-1:0];
    end else if (q[SHR_W-1]) begin
      round_sat = DATA_MIN;
    end else begin
      round_sat = DATA_MAX;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/ksm_cfg_regs.sv =====
`default_nettype none

module ksm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [ksm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ksm_pkg::DATA_W-1:0]    cfg_data_i,
  output logic                          cfg_ready_o,
  output ksm_pkg::cfg_t                 cfg_o
);
  import ksm_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COEF_OLDEST:     cfg_d.coef_oldest     = cfg_data_i[COEF_W-1:0];
        REG_COEF_MIDDLE:     cfg_d.coef_middle     = cfg_data_i[COEF_W-1:0];
        REG_COEF_PREVIOUS:   cfg_d.coef_previous   = cfg_data_i[COEF_W-1:0];
        REG_COEF_SAMPLE:     cfg_d.coef_sample     = cfg_data_i[COEF_W-1:0];
        REG_INVALID_Z_LIMIT: cfg_d.invalid_z_limit = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/ksm_hist_mem.sv =====
`default_nettype none

module ksm_hist_mem #(
  parameter int NUM_POINTS = ksm_pkg::NUM_POINTS_DEF,
  parameter int HIST_LEN   = ksm_pkg::TAPS_DEF - 1,
  localparam int AW        = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [ksm_pkg::NUM_AXES-1:0][HIST_LEN-1:0][ksm_pkg::DATA_W-1:0] rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [ksm_pkg::NUM_AXES-1:0][HIST_LEN-1:0][ksm_pkg::DATA_W-1:0] wdata_i
);
  import ksm_pkg::*;

  typedef logic [NUM_AXES-1:0][HIST_LEN-1:0][DATA_W-1:0] hist_word_t;

  hist_word_t            mem_q [NUM_POINTS];
  logic [NUM_POINTS-1:0] valid_q;
  hist_word_t            rd_q;
  hist_word_t            byp_data_q;
  logic                  rd_valid_q;
  logic                  byp_q;

  // A read that meets a write to the same entry returns the new word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q       <= mem_q[raddr_i];
      byp_data_q <= wdata_i;
    end
  end

  // Entries never written read as zero, which stands for the cleared history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_valid_q <= valid_q[raddr_i];
        byp_q      <= we_i && (waddr_i == raddr_i);
      end
    end
  end

  assign rdata_o = byp_q ? byp_data_q : (rd_valid_q ? rd_q : '0);

endmodule

`default_nettype wire

// ===== design/ksm_filter_pipe.sv =====
`default_nettype none

module ksm_filter_pipe #(
  parameter int HIST_LEN = ksm_pkg::TAPS_DEF - 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ksm_pkg::cfg_t             cfg_i,
  input  logic                      load_i,
  input  ksm_pkg::in_item_t         in_data_i,
  input  logic                      in_range_i,
  input  logic [ksm_pkg::NUM_AXES-1:0][HIST_LEN-1:0][ksm_pkg::DATA_W-1:0] hist_i,
  output logic                      s1_ready_o,
  output ksm_pkg::pipe_status_t     status_o,
  output logic                      we_o,
  output logic [ksm_pkg::IDX_W-1:0] widx_o,
  output logic [ksm_pkg::NUM_AXES-1:0][HIST_LEN-1:0][ksm_pkg::DATA_W-1:0] wdata_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output ksm_pkg::out_item_t        out_data_o
);
  import ksm_pkg::*;

  typedef logic [NUM_AXES-1:0][HIST_LEN-1:0][DATA_W-1:0] hist_word_t;

  // Stage valids and handshake between stages.
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic rdy1, rdy2, rdy3, rdy_out;

  // Stage 1: sample and the history word read for it.
  logic        [IDX_W-1:0]  s1_idx_q;
  logic                     s1_inr_q;
  logic signed [DATA_W-1:0] s1_pos_q [NUM_AXES];

  // Stage 2: products.
  logic        [IDX_W-1:0]  s2_idx_q;
  logic                     s2_inr_q;
  logic                     s2_held_q;
  logic signed [PROD_W-1:0] s2_prod_q [NUM_AXES][4];
  logic signed [PROD_W-1:0] prod_d    [NUM_AXES][4];
  hist_word_t               s2_hist_q;

  // Stage 3: pair sums.
  logic        [IDX_W-1:0]  s3_idx_q;
  logic                     s3_inr_q;
  logic                     s3_held_q;
  logic signed [PAIR_W-1:0] s3_pair_q [NUM_AXES][2];
  logic signed [PAIR_W-1:0] pair_d    [NUM_AXES][2];
  hist_word_t               s3_hist_q;

  out_item_t                out_q, out_d;

  logic signed [DATA_W-1:0] tap    [NUM_AXES][3];
  logic signed [DATA_W-1:0] sample [NUM_AXES];
  logic signed [DATA_W-1:0] y      [NUM_AXES];
  logic                     held1;

  assign rdy_out = !out_v_q || out_ready_i;
  assign rdy3    = !s3_v_q  || rdy_out;
  assign rdy2    = !s2_v_q  || rdy3;
  assign rdy1    = !s1_v_q  || rdy2;

  assign s1_ready_o = rdy1;

  assign status_o.s1_busy = s1_v_q && s1_inr_q;
  assign status_o.s1_idx  = s1_idx_q;
  assign status_o.s2_busy = s2_v_q && s2_inr_q;
  assign status_o.s2_idx  = s2_idx_q;
  assign status_o.s3_busy = s3_v_q && s3_inr_q && !rdy_out;
  assign status_o.s3_idx  = s3_idx_q;

  // tap[a][j] is the j-th most recent stored output; taps beyond the history are zero.
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    for (genvar j = 0; j < 3; j++) begin : g_tap
      if (j < HIST_LEN) begin : g_used
        assign tap[a][j] = hist_i[a][HIST_LEN-1-j];
      end else begin : g_zero
        assign tap[a][j] = '0;
      end
    end
  end

  assign held1 = s1_inr_q && (s1_pos_q[2] < cfg_i.invalid_z_limit);

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sample[a]    = held1 ? tap[a][0] : s1_pos_q[a];
      prod_d[a][0] = mul(cfg_i.coef_sample,   sample[a]);
      prod_d[a][1] = mul(cfg_i.coef_previous, tap[a][0]);
      prod_d[a][2] = mul(cfg_i.coef_middle,   tap[a][1]);
      prod_d[a][3] = mul(cfg_i.coef_oldest,   tap[a][2]);
      pair_d[a][0] = PAIR_W'(s2_prod_q[a][0]) + PAIR_W'(s2_prod_q[a][1]);
      pair_d[a][1] = PAIR_W'(s2_prod_q[a][2]) + PAIR_W'(s2_prod_q[a][3]);
      y[a] = round_sat(SUM_W'(s3_pair_q[a][0]) + SUM_W'(s3_pair_q[a][1]));
    end
  end

  // Write-back word: the history shifts by one and the new output goes in last.
  always_comb begin
    wdata_o = s3_hist_q;
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int k = 0; k < HIST_LEN - 1; k++) begin
        wdata_o[a][k] = s3_hist_q[a][k+1];
      end
      wdata_o[a][HIST_LEN-1] = y[a];
    end
  end

  assign we_o   = s3_v_q && s3_inr_q && rdy_out;
  assign widx_o = s3_idx_q;

  always_comb begin
    out_d.out_index = s3_idx_q;
    out_d.filt_x    = s3_inr_q ? y[0] : '0;
    out_d.filt_y    = s3_inr_q ? y[1] : '0;
    out_d.filt_z    = s3_inr_q ? y[2] : '0;
    out_d.held      = s3_held_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1)    s1_v_q  <= load_i;
      if (rdy2)    s2_v_q  <= s1_v_q;
      if (rdy3)    s3_v_q  <= s2_v_q;
      if (rdy_out) out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_idx_q    <= in_data_i.point_index;
      s1_inr_q    <= in_range_i;
      s1_pos_q[0] <= in_data_i.pos_x;
      s1_pos_q[1] <= in_data_i.pos_y;
      s1_pos_q[2] <= in_data_i.pos_z;
    end
    if (rdy2) begin
      s2_idx_q  <= s1_idx_q;
      s2_inr_q  <= s1_inr_q;
      s2_held_q <= held1;
      s2_prod_q <= prod_d;
      s2_hist_q <= hist_i;
    end
    if (rdy3) begin
      s3_idx_q  <= s2_idx_q;
      s3_inr_q  <= s2_inr_q;
      s3_held_q <= s2_held_q;
      s3_pair_q <= pair_d;
      s3_hist_q <= s2_hist_q;
    end
    if (rdy_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/keypoint_recursive_smoother_top.sv =====
// Keypoint smoother: each accepted sample (keypoint index, x, y, z in Q16.16) yields exactly
// one filtered result, in order. Per keypoint and axis the output is a Q2.14 weighted sum of
// the sample and the last three stored outputs, rounded half up and saturated to 32 bits; a
// sample whose z lies below the limit is replaced by the keypoint's latest output and flagged
// as held. The block takes one sample per cycle unless the output stalls or a hazard holds it.
// The per-keypoint history lives in a single memory word that is read when the sample is taken
// and written back once its result is formed; a sample for a keypoint whose write-back is still
// pending waits, so samples of one keypoint cannot enter back to back, while interleaved
// keypoints run at full rate. The history reads as zero after reset without any clearing pass.
// Configuration is accepted in every cycle and must only change while the block is idle. A
// sample with an index beyond the keypoint count gives zeros and leaves the history alone.
`default_nettype none

module keypoint_recursive_smoother_top #(
  parameter int NUM_POINTS = ksm_pkg::NUM_POINTS_DEF,
  parameter int TAPS       = ksm_pkg::TAPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ksm_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ksm_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ksm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ksm_pkg::DATA_W-1:0]    cfg_data_i
);
  import ksm_pkg::*;

  localparam int HIST_LEN = TAPS - 1;
  localparam int AW       = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

  cfg_t         cfg;
  pipe_status_t status;
  logic         s1_ready;
  logic         hazard;
  logic         in_range;
  logic         accept;
  logic         we;
  logic [IDX_W-1:0] widx;
  logic [NUM_AXES-1:0][HIST_LEN-1:0][DATA_W-1:0] rdata;
  logic [NUM_AXES-1:0][HIST_LEN-1:0][DATA_W-1:0] wdata;

  // Configuration registers.
  ksm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  assign in_range = (32'(in_data_i.point_index) < NUM_POINTS);

  // The sample's keypoint must not be held in stage one or two, nor waiting in stage three,
  // because their history words have not reached the memory yet. A write-back that happens
  // on the very edge of the transfer is forwarded by the memory itself.
  assign hazard = in_range && (
      (status.s1_busy && (status.s1_idx == in_data_i.point_index)) ||
      (status.s2_busy && (status.s2_idx == in_data_i.point_index)) ||
      (status.s3_busy && (status.s3_idx == in_data_i.point_index)));

  assign in_ready_o = s1_ready && !hazard;
  assign accept     = in_valid_i && in_ready_o;

  // History store: one word per keypoint holding every axis and every stored output.
  ksm_hist_mem #(
    .NUM_POINTS (NUM_POINTS),
    .HIST_LEN   (HIST_LEN)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (AW'(in_data_i.point_index)),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (AW'(widx)),
    .wdata_i (wdata)
  );

  // Multiply, add, round and write back, with the output register at the end.
  ksm_filter_pipe #(
    .HIST_LEN (HIST_LEN)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .load_i      (accept),
    .in_data_i   (in_data_i),
    .in_range_i  (in_range),
    .hist_i      (rdata),
    .s1_ready_o  (s1_ready),
    .status_o    (status),
    .we_o        (we),
    .widx_o      (widx),
    .wdata_o     (wdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== design/ksm_checker.sv =====
`default_nettype none

module ksm_checker #(
  parameter int NUM_POINTS = ksm_pkg::NUM_POINTS_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ksm_pkg::out_item_t out_data_o
);
  import ksm_pkg::*;

  // Samples transferred in whose results have not yet been transferred out.
  logic [3:0] inflight_q;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 4'(in_fire) - 4'(out_fire);
    end
  end

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 4'd0)
    else $error("result without an outstanding sample");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == 4'd0 |-> in_ready_o)
    else $error("empty block refuses a sample");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (32'(out_data_o.out_index) >= NUM_POINTS) |->
      out_data_o.filt_x == '0 && out_data_o.filt_y == '0 &&
      out_data_o.filt_z == '0 && !out_data_o.held)
    else $error("result for an unknown keypoint is not zero");

endmodule

bind keypoint_recursive_smoother_top ksm_checker #(
  .NUM_POINTS (NUM_POINTS)
) u_ksm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== tb/sv/keypoint_recursive_smoother_top_test.sv =====
module keypoint_recursive_smoother_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ksm_pkg::*;

  // Stored outputs per keypoint and axis; the last slot holds the newest output.
  localparam int HIST_DEPTH = TAPS_DEF - 1;

  // An ample pause for the pipeline to empty out before a register is touched.
  localparam int LATENCY_PAUSE = 8;

  // Long receiver hold-off used to fill the pipeline and stall the input side.
  localparam int HOLD_OFF_CYCLES = 300;

  // Cycles without any transfer on any channel before the run is abandoned.
  localparam int QUIET_LIMIT = 2000;

  localparam int STREAM_PHASES    = 6;
  localparam int PHASE_SAMPLES    = 160;
  localparam int PRESSURE_SAMPLES = 64;
  localparam int IDLE_PERCENT     = 11;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  localparam logic signed [DATA_W-1:0] Q_ONE    = 32'sd65536;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 16'sh7fff;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 16'sh8000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_item_t            out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DATA_W-1:0]    cfg_data_i;

  // Our own copy of the filter state and of the register file, kept in step with
  // every accepted transfer.
  logic signed [DATA_W-1:0] point_history [NUM_POINTS_DEF][NUM_AXES][HIST_DEPTH];
  cfg_t                     active_cfg = CFG_RESET;

  // Filtered results still owed by the block, oldest first.
  out_item_t pending_results[$];

  int error_count  = 0;
  int quiet_cycles = 0;

  // Switches shared between the test tasks and the two sides' idling.
  bit source_steady = 1'b0;
  bit sink_steady   = 1'b0;
  bit hold_request  = 1'b0;

  keypoint_recursive_smoother_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Computes the filtered result for one accepted sample and updates the stored
  // history of its keypoint. Every product is exact in 64 bits; the sum is
  // rounded half towards plus infinity by an arithmetic shift, then saturated.
  function automatic out_item_t smooth_sample(input in_item_t s);
    out_item_t                r;
    logic signed [DATA_W-1:0] axis_in [NUM_AXES];
    logic signed [DATA_W-1:0] axis_out [NUM_AXES];
    longint                   acc;
    int                       p;
    int                       a;
    int                       k;
    p = s.point_index;
    axis_in[0] = s.pos_x;
    axis_in[1] = s.pos_y;
    axis_in[2] = s.pos_z;
    r.out_index = s.point_index;
    r.held = $signed(s.pos_z) < $signed(active_cfg.invalid_z_limit);
    for (a = 0; a < NUM_AXES; a++) begin
      // An invalid sample is replaced, on every axis, by the keypoint's newest output.
      if (r.held) begin
        axis_in[a] = point_history[p][a][HIST_DEPTH-1];
      end
      acc = longint'($signed(active_cfg.coef_sample)) * longint'(axis_in[a])
          + longint'($signed(active_cfg.coef_previous))
            * longint'(point_history[p][a][HIST_DEPTH-1])
          + longint'($signed(active_cfg.coef_middle))
            * longint'(point_history[p][a][HIST_DEPTH-2])
          + longint'($signed(active_cfg.coef_oldest))
            * longint'(point_history[p][a][HIST_DEPTH-3]);
      acc = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
      if (acc > SAT_HI) begin
        acc = SAT_HI;
      end else if (acc < SAT_LO) begin
        acc = SAT_LO;
      end
      axis_out[a] = acc[DATA_W-1:0];
      for (k = 0; k < HIST_DEPTH - 1; k++) begin
        point_history[p][a][k] = point_history[p][a][k+1];
      end
      point_history[p][a][HIST_DEPTH-1] = axis_out[a];
    end
    r.filt_x = axis_out[0];
    r.filt_y = axis_out[1];
    r.filt_z = axis_out[2];
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d (%h), actual %0d (%h)", $time, field,
               $signed(want), want, $signed(got), got);
      error_count++;
    end
  endtask

  // Everything is sampled on the rising edge, where the inputs have been stable
  // since the falling edge. Results are checked first, then the new sample's
  // expectation is queued, then any register write is applied to our copy.
  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      active_cfg    = CFG_RESET;
      point_history = '{default: '0};
      pending_results.delete();
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %h", $time,
                   out_data_o);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("out_index", DATA_W'(want.out_index), DATA_W'(out_data_o.out_index));
          compare_field("filt_x", want.filt_x, out_data_o.filt_x);
          compare_field("filt_y", want.filt_y, out_data_o.filt_y);
          compare_field("filt_z", want.filt_z, out_data_o.filt_z);
          compare_field("held", DATA_W'(want.held), DATA_W'(out_data_o.held));
        end
      end
      if (in_valid_i && in_ready_o) begin
        pending_results.push_back(smooth_sample(in_data_i));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_COEF_OLDEST:     active_cfg.coef_oldest     = cfg_data_i[COEF_W-1:0];
          REG_COEF_MIDDLE:     active_cfg.coef_middle     = cfg_data_i[COEF_W-1:0];
          REG_COEF_PREVIOUS:   active_cfg.coef_previous   = cfg_data_i[COEF_W-1:0];
          REG_COEF_SAMPLE:     active_cfg.coef_sample     = cfg_data_i[COEF_W-1:0];
          REG_INVALID_Z_LIMIT: active_cfg.invalid_z_limit = cfg_data_i;
          default: ; // Indices past the register list are dropped by the block.
        endcase
      end
    end
  end

  // Any transfer on any channel counts as progress. A stuck handshake ends the run.
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver side. It normally drops ready in about one cycle in nine; when a
  // hold-off is asked for it keeps ready low for a long stretch, counted here.
  initial begin : result_sink
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end
      out_ready_i <= sink_steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Offers one sample and returns on the rising edge of its transfer. Valid is
  // left high, so back-to-back calls give an unbroken stream unless a random
  // one-cycle gap is inserted first.
  task automatic send_sample(input in_item_t item);
    @(negedge clk_i);
    if (!source_steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops offering samples and waits until every owed result has come back,
  // then lets the pipeline go quiet.
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY_PAUSE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Loads a full register set once the block is idle. The upper half of each
  // coefficient write carries noise, since only the low sixteen bits count.
  task automatic apply_settings(input cfg_t c);
    settle_block();
    write_reg(REG_COEF_OLDEST, {COEF_W'($urandom()), c.coef_oldest});
    write_reg(REG_COEF_MIDDLE, {COEF_W'($urandom()), c.coef_middle});
    write_reg(REG_COEF_PREVIOUS, {COEF_W'($urandom()), c.coef_previous});
    write_reg(REG_COEF_SAMPLE, {COEF_W'($urandom()), c.coef_sample});
    write_reg(REG_INVALID_Z_LIMIT, c.invalid_z_limit);
  endtask

  function automatic in_item_t make_sample(input int idx, input logic [DATA_W-1:0] x,
                                           input logic [DATA_W-1:0] y,
                                           input logic [DATA_W-1:0] z);
    in_item_t s;
    s.point_index = IDX_W'(idx);
    s.pos_x = x;
    s.pos_y = y;
    s.pos_z = z;
    return s;
  endfunction

  // Coordinates are mostly modest so that the filter state stays meaningful,
  // with a share of full-range values and of both extremes.
  function automatic logic signed [DATA_W-1:0] random_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      return DATA_W'(int'($urandom_range(1 << 21)) - (1 << 20));
    end else if (pick < 85) begin
      return $urandom();
    end else if (pick < 92) begin
      return DATA_MAX;
    end
    return DATA_MIN;
  endfunction

  // Half the samples go to three keypoints so that their history fills up and
  // same-keypoint samples collide in the pipeline; a quarter of z values sit
  // within two LSBs of the invalid limit.
  function automatic in_item_t random_sample(input logic signed [DATA_W-1:0] z_limit);
    in_item_t s;
    if ($urandom_range(1) == 0) begin
      s.point_index = IDX_W'($urandom_range(2));
    end else begin
      s.point_index = IDX_W'($urandom());
    end
    s.pos_x = random_coord();
    s.pos_y = random_coord();
    if ($urandom_range(3) == 0) begin
      s.pos_z = z_limit + DATA_W'($urandom_range(4)) - DATA_W'(2);
    end else begin
      s.pos_z = random_coord();
    end
    return s;
  endfunction

  // Reset settings pass the sample straight through; this checks the invalid
  // test at and just below the limit, substitution from an empty and from a
  // filled history, field extremes and one keypoint sent back to back.
  task automatic test_default_filter();
    logic signed [DATA_W-1:0] limit;
    limit = CFG_RESET.invalid_z_limit;
    source_steady = 1'b1;
    send_sample(make_sample(0, 0, 0, 0));
    send_sample(make_sample(15, DATA_MAX, DATA_MIN, DATA_MAX));
    send_sample(make_sample(9, 1, 2, DATA_MIN));
    send_sample(make_sample(3, 32'sd98304, -Q_ONE, limit));
    send_sample(make_sample(3, 7, 7, limit - 1));
    send_sample(make_sample(15, 0, 0, DATA_MIN));
    send_sample(make_sample(5, 100, 200, 300));
    send_sample(make_sample(5, -100, -200, -300));
    send_sample(make_sample(5, Q_ONE, Q_ONE, Q_ONE));
    send_sample(make_sample(5, -1, -1, -1));
    send_sample(make_sample(10, 32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f));
    source_steady = 1'b0;
  endtask

  // Writes every register with extreme values, drives the sums into both
  // saturation limits, then writes the unused indices and checks nothing moved.
  task automatic test_register_map();
    cfg_t c;
    c = '{coef_oldest: COEF_MAX, coef_middle: COEF_MAX, coef_previous: COEF_MAX,
          coef_sample: COEF_MAX, invalid_z_limit: DATA_MAX};
    apply_settings(c);
    send_sample(make_sample(2, DATA_MAX, DATA_MIN, DATA_MAX));
    send_sample(make_sample(2, DATA_MAX, DATA_MIN, DATA_MAX));
    send_sample(make_sample(2, 1, -1, DATA_MAX));
    send_sample(make_sample(2, 0, 0, 0));
    c = '{coef_oldest: COEF_MIN, coef_middle: COEF_MIN, coef_previous: COEF_MIN,
          coef_sample: COEF_MIN, invalid_z_limit: DATA_MIN};
    apply_settings(c);
    send_sample(make_sample(4, DATA_MAX, DATA_MIN, 0));
    send_sample(make_sample(4, DATA_MIN, DATA_MAX, DATA_MIN));
    send_sample(make_sample(4, -Q_ONE, Q_ONE, 1));
    settle_block();
    for (int k = int'(REG_INVALID_Z_LIMIT) + 1; k < 2 ** CFG_IDX_W; k++) begin
      write_reg(CFG_IDX_W'(k), $urandom());
    end
    send_sample(make_sample(4, Q_ONE, Q_ONE, Q_ONE));
  endtask

  // With a sample weight of one LSB the output is the input divided by 2^14,
  // which exposes the rounding on exact halves of both signs.
  task automatic test_rounding();
    cfg_t c;
    c = CFG_RESET;
    c.coef_sample = 16'sd1;
    c.invalid_z_limit = DATA_MIN;
    apply_settings(c);
    send_sample(make_sample(6, 8192, -8192, -8193));
    send_sample(make_sample(7, 8191, 24576, -24576));
  endtask

  // Random samples under a series of register settings, from a sensible
  // smoothing filter through random weights, all-maximum and all-minimum to the reset settings.
  // One phase runs with neither side idling.
  task automatic test_random_streams();
    cfg_t c;
    for (int phase = 0; phase < STREAM_PHASES; phase++) begin
      c = CFG_RESET;
      case (phase)
        0: begin
          c.coef_middle   = 16'sd4096;
          c.coef_previous = 16'sd8192;
          c.coef_sample   = 16'sd4096;
        end
        1: begin
          c.coef_oldest     = COEF_W'(int'($urandom_range(32768)) - 16384);
          c.coef_middle     = COEF_W'(int'($urandom_range(32768)) - 16384);
          c.coef_previous   = COEF_W'(int'($urandom_range(32768)) - 16384);
          c.coef_sample     = COEF_W'(int'($urandom_range(32768)) - 16384);
          c.invalid_z_limit = DATA_W'(int'($urandom_range(1 << 21)) - (1 << 20));
        end
        2: begin
          c = '{coef_oldest: COEF_MAX, coef_middle: COEF_MAX, coef_previous: COEF_MAX,
                coef_sample: COEF_MAX, invalid_z_limit: $urandom()};
        end
        3: begin
          c = '{coef_oldest: COEF_MIN, coef_middle: COEF_MIN, coef_previous: COEF_MIN,
                coef_sample: COEF_MIN, invalid_z_limit: $urandom()};
        end
        4: begin
          c = '{coef_oldest: COEF_W'($urandom()), coef_middle: COEF_W'($urandom()),
                coef_previous: COEF_W'($urandom()), coef_sample: COEF_W'($urandom()),
                invalid_z_limit: $urandom()};
        end
        default: ; // Back to the settings the block comes out of reset with.
      endcase
      apply_settings(c);
      source_steady = (phase == 1);
      sink_steady   = (phase == 1);
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        send_sample(random_sample(c.invalid_z_limit));
      end
    end
    source_steady = 1'b0;
    sink_steady   = 1'b0;
  endtask

  // The receiver holds off for a long stretch while samples keep coming, so the
  // pipeline fills and the input side has to stall until the results drain.
  task automatic test_backpressure();
    settle_block();
    source_steady = 1'b1;
    hold_request  = 1'b1;
    for (int n = 0; n < PRESSURE_SAMPLES; n++) begin
      send_sample(random_sample(active_cfg.invalid_z_limit));
    end
    source_steady = 1'b0;
  endtask

  initial begin : test_sequence
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_filter();
    test_register_map();
    test_rounding();
    test_random_streams();
    test_backpressure();

    settle_block();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
